/* hdl/amplitude_period_pair_histogram_macros.svh */
// assertion helpers shared by the histogram rtl
// each expects clk and arst_n in scope
`ifndef AMPLITUDE_PERIOD_PAIR_HISTOGRAM_MACROS_SVH
`define AMPLITUDE_PERIOD_PAIR_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define APPH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APPH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/apph_pkg.sv */
`timescale 1ns / 1ps
package apph_pkg;

	// fixed field widths
	localparam int FIELD_W = 16;
	localparam int HITS_W  = 16;
	localparam int RIDX_W  = 8;
	localparam int USED_W  = 9;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 64;

	localparam logic [USED_W-1:0] LIMIT_RESET = 9'd256;
	localparam logic [HITS_W-1:0] HITS_MAX    = 16'hFFFF;

	// commands
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_FEED  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// outcome codes
	localparam logic [2:0] OUT_NONE   = 3'd0;
	localparam logic [2:0] OUT_MATCH  = 3'd1;
	localparam logic [2:0] OUT_INSERT = 3'd2;
	localparam logic [2:0] OUT_DROP   = 3'd3;
	localparam logic [2:0] OUT_DONE   = 3'd4;

	// what a token still has to do in the chain
	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_PAIR = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// token handed from cell to cell (amplitude and count travel beside it)
	typedef struct packed {
		logic              valid;
		logic [1:0]        kind;
		logic [2:0]        outcome;
		logic [FIELD_W-1:0] hp;
		logic [HITS_W-1:0]  hits;
		logic [RIDX_W-1:0]  ridx;
	} apph_tok_t;

	// search status reported by a cell
	typedef struct packed {
		logic decide;
		logic insert;
	} apph_stat_t;

endpackage

/* hdl/apph_cell.sv */
`timescale 1ns / 1ps
`include "amplitude_period_pair_histogram_macros.svh"
module apph_cell import apph_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int IDX         = 0,
	parameter int AMP_W       = 16,
	parameter int CNT_W       = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [USED_W-1:0] limit,
	input  apph_tok_t         in_tok,
	input  logic [AMP_W-1:0]  in_amp,
	input  logic [CNT_W-1:0]  in_cnt,
	output apph_tok_t         out_tok,
	output logic [AMP_W-1:0]  out_amp,
	output logic [CNT_W-1:0]  out_cnt,
	output apph_stat_t        stat
);

	localparam logic LAST = (IDX == TABLE_DEPTH - 1);

	// stored entry
	logic [AMP_W-1:0]   entry_amp_q;
	logic [FIELD_W-1:0] entry_hp_q;
	logic [HITS_W-1:0]  entry_hits_q;

	// token register
	apph_tok_t        tok_q;
	logic [AMP_W-1:0] amp_q;
	logic [CNT_W-1:0] cnt_q;

	logic             live;
	logic             below;
	logic             at_free;
	logic             match;
	logic             miss;
	logic             fits;
	logic             insert;
	logic             read_hit;
	logic [HITS_W-1:0] hits_inc;
	apph_tok_t        nxt_tok;
	logic [AMP_W-1:0] nxt_amp;
	logic [CNT_W-1:0] nxt_cnt;

	// entry compares
	assign live     = in_tok.valid && (in_tok.kind == KIND_PAIR);
	assign below    = 32'(in_cnt) > 32'(IDX);
	assign at_free  = 32'(in_cnt) == 32'(IDX);
	assign match    = live && below && (entry_amp_q == in_amp) && (entry_hp_q == in_tok.hp);
	assign miss     = live && !match && (at_free || LAST);
	assign fits     = at_free && (32'(limit) > 32'(IDX));
	assign insert   = miss && fits;
	assign read_hit = in_tok.valid && (in_tok.kind == KIND_READ) && below
		&& (32'(in_tok.ridx) == 32'(IDX));
	assign hits_inc = (entry_hits_q == HITS_MAX) ? entry_hits_q : entry_hits_q + HITS_W'(1);

	// token update
	always_comb begin
		nxt_tok = in_tok;
		nxt_amp = in_amp;
		nxt_cnt = in_cnt;
		if (match) begin
			nxt_tok.kind    = KIND_PASS;
			nxt_tok.outcome = OUT_MATCH;
			nxt_tok.hits    = hits_inc;
		end else if (insert) begin
			nxt_tok.kind    = KIND_PASS;
			nxt_tok.outcome = OUT_INSERT;
			nxt_tok.hits    = HITS_W'(1);
			nxt_cnt         = in_cnt + CNT_W'(1);
		end else if (miss) begin
			nxt_tok.kind    = KIND_PASS;
			nxt_tok.outcome = OUT_DROP;
			nxt_tok.hits    = '0;
		end else if (read_hit) begin
			nxt_tok.kind = KIND_PASS;
			nxt_tok.hp   = entry_hp_q;
			nxt_tok.hits = entry_hits_q;
			nxt_amp      = entry_amp_q;
		end
	end

	assign stat.decide = match || miss;
	assign stat.insert = insert;

	// entry storage, written on a hit or on an insert into this cell
	always_ff @(posedge clk) begin
		if (en && (match || insert)) begin
			if (insert) begin
				entry_amp_q  <= in_amp;
				entry_hp_q   <= in_tok.hp;
				entry_hits_q <= HITS_W'(1);
			end else begin
				entry_hits_q <= hits_inc;
			end
		end
	end

	// hand the token on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= nxt_tok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amp_q <= nxt_amp;
			cnt_q <= nxt_cnt;
		end
	end

	assign out_tok = tok_q;
	assign out_amp = amp_q;
	assign out_cnt = cnt_q;

	`APPH_ASSERT_IMP(a_cell_one_action, 1'b1, !((match || miss) && read_hit), "cell took two actions on one item")
	`APPH_ASSERT_IMP(a_cell_insert_free, insert, at_free && !match, "insert into a cell already in use")
	`APPH_ASSERT_NXT(a_cell_resolved, en && (match || miss), tok_q.kind == KIND_PASS, "resolved search still marked open")

endmodule

/* hdl/amplitude_period_pair_histogram.sv */
`timescale 1ns / 1ps
// path: an accepted item passes through the front register and then each cell's register to its result
// throughput: one item per cycle for clear, read and unpaired points while the output is not stalled;
// a paired point holds the input until its search token reaches cell k, where its key matches, or the
// first free cell, or the last cell (k < TABLE_DEPTH), walking one cell per cycle when not stalled
// reset: clears pairing state, used count, pending search and table_limit (to 256);
// table contents are left as they are and need no clearing pass
`include "amplitude_period_pair_histogram_macros.svh"
module amplitude_period_pair_histogram import apph_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// cmd
	input  logic [1:0]          s_tuser,
	// point_amplitude, point_half_period, window_start, read_index, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// outcome
	output logic [2:0]          m_tuser,
	// entries_used, entry_amplitude, entry_half_period, entry_hits, zero pad
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [USED_W-1:0]   cfg_data
);

	localparam int AMP_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [USED_W-1:0] table_limit_q;
	logic [CNT_W-1:0]  used_count_q;
	logic [AMP_W-1:0]  prev_amp_q;
	logic              prev_valid_q;
	logic              skip_q;
	logic              pending_q;

	logic              en;
	logic              accept;
	logic [1:0]        cmd;
	logic [AMP_W-1:0]  amp_in;
	logic [FIELD_W-1:0] hp_in;
	logic              wstart;
	logic [RIDX_W-1:0] ridx_in;
	logic [AMP_W-1:0]  diff;

	apph_tok_t         fr_tok;
	logic [AMP_W-1:0]  fr_amp;
	logic [CNT_W-1:0]  fr_cnt;
	apph_tok_t         tok_s1;
	logic [AMP_W-1:0]  amp_s1;
	logic [CNT_W-1:0]  cnt_s1;

	apph_tok_t         tok_c [0:TABLE_DEPTH];
	logic [AMP_W-1:0]  amp_c [0:TABLE_DEPTH];
	logic [CNT_W-1:0]  cnt_c [0:TABLE_DEPTH];
	apph_stat_t        stat  [0:TABLE_DEPTH-1];
	logic [TABLE_DEPTH-1:0] decide_vec;
	logic [TABLE_DEPTH-1:0] insert_vec;

	// input unpacking
	assign cmd     = s_tuser;
	assign amp_in  = s_tdata[AMP_W-1:0];
	assign hp_in   = s_tdata[31:16];
	assign wstart  = s_tdata[32];
	assign ridx_in = s_tdata[40:33];
	assign diff    = (amp_in >= prev_amp_q) ? amp_in - prev_amp_q : prev_amp_q - amp_in;

	// chain advances whenever the output register is free or being taken
	assign en        = !tok_c[TABLE_DEPTH].valid || m_tready;
	assign s_tready  = en && !pending_q;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// build the token for an accepted item
	always_comb begin
		fr_tok       = '0;
		fr_amp       = '0;
		fr_cnt       = used_count_q;
		fr_tok.valid = accept;
		unique case (cmd)
			CMD_CLEAR: begin
				fr_tok.outcome = OUT_DONE;
				fr_cnt         = '0;
			end
			CMD_READ: begin
				fr_tok.kind    = KIND_READ;
				fr_tok.outcome = OUT_DONE;
				fr_tok.ridx    = ridx_in;
			end
			CMD_FEED: begin
				if (!wstart && !skip_q && prev_valid_q) begin
					fr_tok.kind = KIND_PAIR;
					fr_tok.hp   = hp_in;
					fr_amp      = diff;
				end
			end
			default: ;
		endcase
	end

	// control state: pairing, used count, outstanding search, limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= LIMIT_RESET;
			used_count_q  <= '0;
			prev_amp_q    <= '0;
			prev_valid_q  <= 1'b0;
			skip_q        <= 1'b0;
			pending_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_limit_q <= cfg_data;
			end
			if (accept) begin
				case (cmd)
					CMD_CLEAR: used_count_q <= '0;
					CMD_FEED: begin
						if (wstart) begin
							skip_q       <= 1'b1;
							prev_valid_q <= 1'b0;
						end else if (skip_q || !prev_valid_q) begin
							skip_q       <= 1'b0;
							prev_amp_q   <= amp_in;
							prev_valid_q <= 1'b1;
						end else begin
							prev_amp_q <= amp_in;
							pending_q  <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (en && (|decide_vec)) begin
				pending_q <= 1'b0;
				if (|insert_vec) begin
					used_count_q <= used_count_q + CNT_W'(1);
				end
			end
		end
	end

	// front register ahead of the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (en) begin
			tok_s1 <= fr_tok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amp_s1 <= fr_amp;
			cnt_s1 <= fr_cnt;
		end
	end

	assign tok_c[0] = tok_s1;
	assign amp_c[0] = amp_s1;
	assign cnt_c[0] = cnt_s1;

	// row of table cells
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		apph_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX        (g),
			.AMP_W      (AMP_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.limit  (table_limit_q),
			.in_tok (tok_c[g]),
			.in_amp (amp_c[g]),
			.in_cnt (cnt_c[g]),
			.out_tok(tok_c[g+1]),
			.out_amp(amp_c[g+1]),
			.out_cnt(cnt_c[g+1]),
			.stat   (stat[g])
		);
		assign decide_vec[g] = stat[g].decide;
		assign insert_vec[g] = stat[g].insert;
	end

	// result from the last cell's register
	assign m_tvalid = tok_c[TABLE_DEPTH].valid;
	assign m_tuser  = tok_c[TABLE_DEPTH].outcome;
	assign m_tdata  = M_DATA_W'({tok_c[TABLE_DEPTH].hits, tok_c[TABLE_DEPTH].hp,
		FIELD_W'(amp_c[TABLE_DEPTH]), USED_W'(cnt_c[TABLE_DEPTH])});

	`APPH_ASSERT_IMP(a_one_decider, 1'b1, $onehot0(decide_vec), "more than one cell resolved a search")
	`APPH_ASSERT_IMP(a_decide_pending, |decide_vec, pending_q, "search resolved with none outstanding")
	`APPH_ASSERT_IMP(a_used_bound, 1'b1, used_count_q <= CNT_W'(TABLE_DEPTH), "used count beyond table depth")
	`APPH_ASSERT_NXT(a_insert_count, en && (|insert_vec), used_count_q == $past(used_count_q) + CNT_W'(1), "insert did not advance used count")

endmodule
